[rtl/core/lcpt_pkg.sv]
// ----------------------------------------------------------------------------
// lcpt_pkg
// shared types, codes and saturation helpers for the probe trigger block
// ----------------------------------------------------------------------------
package lcpt_pkg;

    // configuration register indexes
    typedef enum logic [3:0] {
        REG_GAIN    = 4'd0,
        REG_B0      = 4'd1,
        REG_B1      = 4'd2,
        REG_B2      = 4'd3,
        REG_A1      = 4'd4,
        REG_A2      = 4'd5,
        REG_UPPER   = 4'd6,
        REG_LOWER   = 4'd7
    } cfg_idx_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XSAT,
        ST_B0,
        ST_B1,
        ST_B2,
        ST_A1,
        ST_A2,
        ST_FIN
    } state_t;

    // operand pair for the shared multiplier
    typedef enum logic [2:0] {
        MUL_GAIN,
        MUL_B0,
        MUL_B1,
        MUL_B2,
        MUL_A1,
        MUL_A2
    } mul_sel_t;

    // datapath update that consumes the registered product
    typedef enum logic [2:0] {
        OP_NONE,
        OP_X,
        OP_Y,
        OP_BX1,
        OP_BX2,
        OP_D1,
        OP_D2
    } dp_op_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        dp_op_t   op;
        logic     load_out;
    } dp_cmd_t;

    localparam logic signed [63:0] ROUND_HALF = 64'sd536870912;

    // saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v[63:31] == '0 || v[63:31] == '1)
            r = v[31:0];
        else if (v[63])
            r = 32'sh8000_0000;
        else
            r = 32'sh7FFF_FFFF;
        return r;
    endfunction

    // saturate a 42-bit signed sum to 40 bits
    function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
        logic signed [39:0] r;
        if (v[41:39] == '0 || v[41:39] == '1)
            r = v[39:0];
        else if (v[41])
            r = 40'sh80_0000_0000;
        else
            r = 40'sh7F_FFFF_FFFF;
        return r;
    endfunction

endpackage

[rtl/core/lcpt_ctrl.sv]
// ----------------------------------------------------------------------------
// lcpt_ctrl
// sequencer for the shared multiplier and the output beat register
// ----------------------------------------------------------------------------
module lcpt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output lcpt_pkg::dp_cmd_t cmd
);
    import lcpt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_XSAT;
            ST_XSAT: state_next = ST_B0;
            ST_B0:   state_next = ST_B1;
            ST_B1:   state_next = ST_B2;
            ST_B2:   state_next = ST_A1;
            ST_A1:   state_next = ST_A2;
            ST_A2:   state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.mul_en   = 1'b0;
        cmd.mul_sel  = MUL_GAIN;
        cmd.op       = OP_NONE;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                cmd.mul_en  = in_valid;
                cmd.mul_sel = MUL_GAIN;
            end
            ST_XSAT: cmd.op = OP_X;
            ST_B0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_B0;
            end
            ST_B1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_B1;
                cmd.op      = OP_Y;
            end
            ST_B2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_B2;
                cmd.op      = OP_BX1;
            end
            ST_A1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_A1;
                cmd.op      = OP_BX2;
            end
            ST_A2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_A2;
                cmd.op      = OP_D1;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.op       = OP_D2;
                    cmd.load_out = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/core/lcpt_dp.sv]
// ----------------------------------------------------------------------------
// lcpt_dp
// register file, shared 32x32 multiplier, biquad state and comparator
// ----------------------------------------------------------------------------
module lcpt_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  lcpt_pkg::dp_cmd_t   cmd,
    input  logic [23:0]         raw_word,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    output logic signed [23:0]  sample_value,
    output logic signed [31:0]  filtered,
    output logic                probe_line
);
    import lcpt_pkg::*;

    logic signed [31:0] gain_reg;
    logic signed [31:0] b0_reg;
    logic signed [31:0] b1_reg;
    logic signed [31:0] b2_reg;
    logic signed [31:0] a1_reg;
    logic signed [31:0] a2_reg;
    logic signed [31:0] upper_reg;
    logic signed [31:0] lower_reg;

    logic signed [23:0] sample_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic signed [33:0] t1_reg;
    logic signed [33:0] t2_reg;
    logic signed [39:0] d1_reg;
    logic signed [39:0] d2_reg;
    logic               line_reg;
    logic               line_next;
    logic signed [23:0] samp_out_reg;
    logic signed [31:0] filt_out_reg;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    logic signed [63:0] prod_rnd;
    logic signed [33:0] rnd;
    logic signed [63:0] y_sum;
    logic signed [41:0] d1_sum;
    logic signed [41:0] d2_sum;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= 32'sd65536;
            b0_reg    <= 32'sh4000_0000;
            b1_reg    <= '0;
            b2_reg    <= '0;
            a1_reg    <= '0;
            a2_reg    <= '0;
            upper_reg <= 32'sh7FFF_FFFF;
            lower_reg <= 32'sh8000_0000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN:  gain_reg  <= cfg_wdata;
                REG_B0:    b0_reg    <= cfg_wdata;
                REG_B1:    b1_reg    <= cfg_wdata;
                REG_B2:    b2_reg    <= cfg_wdata;
                REG_A1:    a1_reg    <= cfg_wdata;
                REG_A2:    a2_reg    <= cfg_wdata;
                REG_UPPER: upper_reg <= cfg_wdata;
                REG_LOWER: lower_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_GAIN:
            begin
                mul_a = gain_reg;
                mul_b = {{8{raw_word[23]}}, raw_word};
            end
            MUL_B0:
            begin
                mul_a = b0_reg;
                mul_b = x_reg;
            end
            MUL_B1:
            begin
                mul_a = b1_reg;
                mul_b = x_reg;
            end
            MUL_B2:
            begin
                mul_a = b2_reg;
                mul_b = x_reg;
            end
            MUL_A1:
            begin
                mul_a = a1_reg;
                mul_b = y_reg;
            end
            MUL_A2:
            begin
                mul_a = a2_reg;
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = gain_reg;
                mul_b = x_reg;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;

    // q30 product back to q16.16, round half up
    assign prod_rnd = prod_reg + ROUND_HALF;
    assign rnd      = prod_rnd[63:30];

    assign y_sum  = {{30{rnd[33]}}, rnd} + {{24{d1_reg[39]}}, d1_reg};
    assign d1_sum = {{8{t1_reg[33]}}, t1_reg} + {{8{rnd[33]}}, rnd}
                  + {{2{d2_reg[39]}}, d2_reg};
    assign d2_sum = {{8{t2_reg[33]}}, t2_reg} + {{8{rnd[33]}}, rnd};

    // hysteresis, upper test wins
    always_comb
    begin
        if (y_reg > upper_reg)
            line_next = 1'b0;
        else if (y_reg < lower_reg)
            line_next = 1'b1;
        else
            line_next = line_reg;
    end

    // payload path
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            sample_reg <= raw_word;
        if (cmd.mul_en)
            prod_reg <= mul_p;
        case (cmd.op)
            OP_X:    x_reg  <= sat32(prod_reg);
            OP_Y:    y_reg  <= sat32(y_sum);
            OP_BX1:  t1_reg <= rnd;
            OP_BX2:  t2_reg <= rnd;
            default: ;
        endcase
        if (cmd.load_out)
        begin
            samp_out_reg <= sample_reg;
            filt_out_reg <= y_reg;
        end
    end

    // filter state and line level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg   <= '0;
            d2_reg   <= '0;
            line_reg <= 1'b1;
        end
        else
        begin
            if (cmd.op == OP_D1)
                d1_reg <= sat40(d1_sum);
            if (cmd.op == OP_D2)
                d2_reg <= sat40(d2_sum);
            if (cmd.load_out)
                line_reg <= line_next;
        end
    end

    assign sample_value = samp_out_reg;
    assign filtered     = filt_out_reg;
    assign probe_line   = line_reg;

endmodule

[rtl/core/load_cell_probe_trigger_unit.sv]
// ----------------------------------------------------------------------------
// load_cell_probe_trigger_unit
// load cell conditioning: gain, one biquad section and a hysteresis trigger
// ----------------------------------------------------------------------------
// Each input beat carries one raw 24-bit ADC word and yields exactly one output
// beat with the raw sample, the filtered Q16.16 level and the probe line
// level (0 means triggered). The input stays closed until FIN has passed: the
// accept step in IDLE also starts the gain product, then over XSAT, B0, B1, B2,
// A1, A2 and FIN a single shared 32x32 multiplier works through the five
// biquad products and the datapath folds each rounded product into the output
// and the two 40-bit delay terms. The output register frees the input side as
// soon as its beat is loaded; if the previous result has not been taken by
// then, the last step waits until it is. Configuration writes take effect at
// once and are meant to happen only while the block is idle.
// ----------------------------------------------------------------------------
module load_cell_probe_trigger_unit (
    input  logic                clk,
    input  logic                rst_n,
    // input beats
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [23:0]         raw_word,
    // output beats
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [23:0]  sample_value,
    output logic signed [31:0]  filtered,
    output logic                probe_line,
    // register writes
    input  logic                cfg_we,
    input  logic [3:0]          cfg_index,
    input  logic [31:0]         cfg_wdata
);
    import lcpt_pkg::*;

    // command word from the sequencer to the datapath
    dp_cmd_t cmd;

    // sequencer: owns the handshakes and steps the multiplier
    lcpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // datapath: registers, multiplier, filter state, comparator
    lcpt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .raw_word     (raw_word),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .sample_value (sample_value),
        .filtered     (filtered),
        .probe_line   (probe_line)
    );

endmodule

[rtl/core/lcpt_checker.sv]
// ----------------------------------------------------------------------------
// lcpt_checker
// port-level checks on beat pacing and output stability
// ----------------------------------------------------------------------------
module lcpt_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [23:0]         raw_word,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic signed [23:0]  sample_value,
    input  logic signed [31:0]  filtered,
    input  logic                probe_line,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_index,
    input  logic [31:0]         cfg_wdata
);

    // a waiting output beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_value)
            && $stable(filtered) && $stable(probe_line))
        else $error("output beat changed while stalled");

    // an accepted item keeps the input closed while its product steps run
    a_in_pacing: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready
            ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("input reopened before item finished");

    // probe line only moves together with a fresh output beat
    a_line_with_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(probe_line) |-> out_valid)
        else $error("probe line moved without an output beat");

    // a new output beat appears only with the input side idle-ready
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("output beat raised mid-item");

endmodule

bind load_cell_probe_trigger_unit lcpt_checker u_lcpt_checker (.*);
